FILE: hdl/lahacc_pkg.sv
// ============================================================================
// lahacc_pkg
// Shared types, codes, hash constants and the log-add correction ROM.
// ============================================================================
package lahacc_pkg;

  localparam int TABLE_SLOTS            = 1024;
  localparam int CORRECTION_ROM_ENTRIES = 1024;
  localparam int SLOT_W                 = $clog2(TABLE_SLOTS);
  localparam int CNT_W                  = SLOT_W + 1;
  localparam int ROM_W                  = $clog2(CORRECTION_ROM_ENTRIES);

  // operation codes
  localparam logic [1:0] OP_UPDATE = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_INSERT = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // status codes
  localparam logic [2:0] ST_COMBINED  = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  localparam logic [9:0] MAX_ENTRIES_RST = 10'd512;

  // XXH64 primes
  localparam logic [63:0] PR1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] PR2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] PR3 = 64'h165667B19E3779F9;
  localparam logic [63:0] PR4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] PR5 = 64'h27D4EB2F165667C5;
  localparam logic [63:0] HASH_SEED = 64'd1337;
  localparam logic [63:0] HASH_H0   = HASH_SEED + PR5 + 64'd8;

  localparam logic [63:0] EXP_STEP_Q31 = 64'd2114190000;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic [31:0]        log_value;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_value;
    logic [9:0]  entry_index;
  } out_word_t;

  // work item handed from the front end to the table engine
  typedef struct packed {
    logic [1:0]        op;
    logic [63:0]       key;
    logic [31:0]       value;
    logic [SLOT_W-1:0] home;
  } job_t;

  typedef logic [31:0] corr_rom_t [CORRECTION_ROM_ENTRIES];

  // restoring division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // ln(1+y), y in Q0.31, result Q16.16 rounded (atanh series)
  function automatic logic [31:0] ln1p_q16(input logic [63:0] y);
    logic [63:0] z, z2, term, sum, sq, t2;
    z    = udiv64(y << 32, (64'd1 << 32) + y);
    sq   = z * z;
    z2   = (sq + (64'd1 << 31)) >> 32;
    term = z;
    sum  = '0;
    for (int n = 0; n < 16; n++) begin
      sum  = sum + udiv64(term, 64'(2 * n + 1));
      t2   = term * z2;
      term = t2 >> 32;
    end
    t2 = ((sum << 1) + 64'd32768) >> 16;
    return t2[31:0];
  endfunction

  function automatic corr_rom_t build_corr_rom();
    corr_rom_t   rom;
    logic [63:0] e, p;
    e = 64'd1 << 31;
    for (int k = 0; k < CORRECTION_ROM_ENTRIES; k++) begin
      rom[k] = ln1p_q16(e);
      p      = e * EXP_STEP_Q31 + (64'd1 << 30);
      e      = p >> 31;
    end
    return rom;
  endfunction

  localparam corr_rom_t CORR_ROM = build_corr_rom();

endpackage

FILE: hdl/lahacc_hash.sv
// ============================================================================
// lahacc_hash
// Front end: takes input words, runs XXH64 on one shared 32x32 multiplier.
// ============================================================================
module lahacc_hash (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lahacc_pkg::in_word_t in_word,
  output logic                 q_push,
  output lahacc_pkg::job_t     q_data,
  input  logic                 q_full
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [2:0]       mul_r;
  logic [2:0]       ph_r;
  logic [63:0]      a_r, acc_r, prod_r;
  lahacc_pkg::job_t job_r;
  logic [63:0]      b_c, post_c, t_c;
  logic [31:0]      ma_c, mb_c;
  logic [63:0]      prod_c;
  logic             accept_c;

  assign in_stall = (state_r != F_IDLE);
  assign accept_c = in_valid && (state_r == F_IDLE);
  assign q_push   = (state_r == F_PUSH) && !q_full;
  assign q_data   = job_r;

  always_comb begin
    case (mul_r)
      3'd0:    b_c = lahacc_pkg::PR2;
      3'd1:    b_c = lahacc_pkg::PR1;
      3'd2:    b_c = lahacc_pkg::PR1;
      3'd3:    b_c = lahacc_pkg::PR2;
      default: b_c = lahacc_pkg::PR3;
    endcase
  end

  // partial products of the low 64 bits of a*b
  always_comb begin
    case (ph_r)
      3'd0: begin
        ma_c = a_r[31:0];
        mb_c = b_c[31:0];
      end
      3'd1: begin
        ma_c = a_r[31:0];
        mb_c = b_c[63:32];
      end
      default: begin
        ma_c = a_r[63:32];
        mb_c = b_c[31:0];
      end
    endcase
  end

  assign prod_c = {32'd0, ma_c} * {32'd0, mb_c};

  // mixing between products
  always_comb begin
    t_c = '0;
    case (mul_r)
      3'd0: post_c = {acc_r[32:0], acc_r[63:33]};
      3'd1: begin
        t_c    = lahacc_pkg::HASH_H0 ^ acc_r;
        post_c = {t_c[36:0], t_c[63:37]};
      end
      3'd2: begin
        t_c    = acc_r + lahacc_pkg::PR4;
        post_c = t_c ^ (t_c >> 33);
      end
      3'd3:    post_c = acc_r ^ (acc_r >> 29);
      default: post_c = acc_r ^ (acc_r >> 32);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept_c) begin
          state_nxt = (in_word.operation == lahacc_pkg::OP_CLEAR) ? F_PUSH : F_HASH;
        end
      end
      F_HASH: begin
        if (ph_r == 3'd4 && mul_r == 3'd4) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      mul_r   <= '0;
      ph_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept_c) begin
        mul_r <= '0;
        ph_r  <= '0;
      end else if (state_r == F_HASH) begin
        if (ph_r == 3'd4) begin
          ph_r  <= '0;
          mul_r <= mul_r + 3'd1;
        end else begin
          ph_r <= ph_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_c) begin
      job_r.op    <= in_word.operation;
      job_r.key   <= {in_word.key_y, in_word.key_x};
      job_r.value <= in_word.log_value;
      job_r.home  <= '0;
      a_r         <= {in_word.key_y, in_word.key_x};
    end else if (state_r == F_HASH) begin
      case (ph_r)
        3'd0: prod_r <= prod_c;
        3'd1: begin
          acc_r  <= prod_r;
          prod_r <= prod_c;
        end
        3'd2: begin
          acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
          prod_r       <= prod_c;
        end
        3'd3: acc_r[63:32] <= acc_r[63:32] + prod_r[31:0];
        default: begin
          a_r <= post_c;
          if (mul_r == 3'd4) begin
            job_r.home <= post_c[lahacc_pkg::SLOT_W-1:0];
          end
        end
      endcase
    end
  end

endmodule

FILE: hdl/lahacc_queue.sv
// ============================================================================
// lahacc_queue
// Two-entry job queue between the hash front end and the table engine.
// ============================================================================
module lahacc_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lahacc_pkg::job_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output lahacc_pkg::job_t pop_data
);

  lahacc_pkg::job_t mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == 2'd2);
  assign pop_valid = (cnt_r != 2'd0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop)  rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

FILE: hdl/lahacc_engine.sv
// ============================================================================
// lahacc_engine
// Back end: slot/key/value memories, linear probe, log-add and result reg.
// ============================================================================
module lahacc_engine (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [9:0]            max_entries,
  input  logic                  q_valid,
  input  lahacc_pkg::job_t      q_data,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lahacc_pkg::out_word_t out_word
);

  localparam int SW = lahacc_pkg::SLOT_W;
  localparam int CW = lahacc_pkg::CNT_W;
  localparam int RW = lahacc_pkg::ROM_W;

  localparam logic [3:0] E_SWEEP    = 4'd0;
  localparam logic [3:0] E_IDLE     = 4'd1;
  localparam logic [3:0] E_RD_SLOT  = 4'd2;
  localparam logic [3:0] E_CHK_SLOT = 4'd3;
  localparam logic [3:0] E_CHK_KEY  = 4'd4;
  localparam logic [3:0] E_LA_ROM   = 4'd5;
  localparam logic [3:0] E_LA_SUM   = 4'd6;
  localparam logic [3:0] E_OUT      = 4'd7;

  typedef struct packed {
    logic          used;
    logic [SW-1:0] ent;
  } slot_t;

  // memories
  slot_t       slot_mem [lahacc_pkg::TABLE_SLOTS];
  logic [63:0] key_mem  [lahacc_pkg::TABLE_SLOTS];
  logic [31:0] val_mem  [lahacc_pkg::TABLE_SLOTS];
  slot_t       slot_q;
  logic [63:0] key_q;
  logic [31:0] val_q, rom_q;

  logic [3:0]            state_r, state_nxt;
  lahacc_pkg::job_t      job_r;
  logic [SW-1:0]         slot_r, sweep_r, ent_r;
  logic [CW-1:0]         count_r;
  logic                  clr_r;
  logic [31:0]           hi_r, diff_r;
  logic                  inrom_r;
  lahacc_pkg::out_word_t res_r, out_r;
  logic                  out_valid_r;

  logic          full_c, ins_c, out_free_c;
  logic [31:0]   lim_c, hi_c, lo_c;
  logic [32:0]   sum_c;
  logic [31:0]   sat_c;
  slot_t         swr_data_c;
  logic [SW-1:0] swr_addr_c;
  logic          swr_en_c;
  logic [SW-1:0] e_c;

  assign out_valid  = out_valid_r;
  assign out_word   = out_r;
  assign out_free_c = !out_valid_r || !out_stall;
  assign q_pop      = (state_r == E_IDLE) && q_valid;
  assign e_c        = count_r[SW-1:0];

  assign lim_c  = (32'(max_entries) < 32'(lahacc_pkg::TABLE_SLOTS - 1)) ?
                  32'(max_entries) : 32'(lahacc_pkg::TABLE_SLOTS - 1);
  assign full_c = 32'(count_r) >= lim_c;
  // empty slot reached by an update or insert that is not refused
  assign ins_c  = (state_r == E_CHK_SLOT) && !slot_q.used &&
                  (job_r.op != lahacc_pkg::OP_LOOKUP) && !full_c;

  assign hi_c  = (val_q > job_r.value) ? val_q : job_r.value;
  assign lo_c  = (val_q > job_r.value) ? job_r.value : val_q;
  assign sum_c = {1'b0, hi_r} + {1'b0, (inrom_r ? rom_q : 32'd0)};
  assign sat_c = sum_c[32] ? 32'hFFFF_FFFF : sum_c[31:0];

  // slot memory write port: clearing sweep or new entry
  always_comb begin
    swr_en_c   = 1'b0;
    swr_addr_c = slot_r;
    swr_data_c = '{used: 1'b1, ent: e_c};
    if (state_r == E_SWEEP) begin
      swr_en_c   = 1'b1;
      swr_addr_c = sweep_r;
      swr_data_c = '0;
    end else if (ins_c) begin
      swr_en_c = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (swr_en_c) slot_mem[swr_addr_c] <= swr_data_c;
    slot_q <= slot_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (ins_c) begin
      key_mem[e_c] <= job_r.key;
    end
    key_q <= key_mem[slot_q.ent];
  end

  always_ff @(posedge clk) begin
    if (ins_c) begin
      val_mem[e_c] <= job_r.value;
    end else if (state_r == E_LA_SUM) begin
      val_mem[ent_r] <= sat_c;
    end
    val_q <= val_mem[slot_q.ent];
  end

  always_ff @(posedge clk) begin
    rom_q <= lahacc_pkg::CORR_ROM[diff_r[10 +: RW]];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      E_SWEEP: begin
        if (sweep_r == SW'(lahacc_pkg::TABLE_SLOTS - 1)) begin
          state_nxt = clr_r ? E_OUT : E_IDLE;
        end
      end
      E_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_data.op == lahacc_pkg::OP_CLEAR) ? E_SWEEP : E_RD_SLOT;
        end
      end
      E_RD_SLOT: state_nxt = E_CHK_SLOT;
      E_CHK_SLOT: begin
        if (!slot_q.used) begin
          state_nxt = E_OUT;
        end else if (job_r.op == lahacc_pkg::OP_INSERT) begin
          state_nxt = E_RD_SLOT;
        end else begin
          state_nxt = E_CHK_KEY;
        end
      end
      E_CHK_KEY: begin
        if (key_q != job_r.key) begin
          state_nxt = E_RD_SLOT;
        end else if (job_r.op == lahacc_pkg::OP_LOOKUP) begin
          state_nxt = E_OUT;
        end else begin
          state_nxt = E_LA_ROM;
        end
      end
      E_LA_ROM: state_nxt = E_LA_SUM;
      E_LA_SUM: state_nxt = E_OUT;
      E_OUT: begin
        if (out_free_c) state_nxt = E_IDLE;
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_SWEEP;
      sweep_r     <= '0;
      clr_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == E_SWEEP) sweep_r <= sweep_r + SW'(1);
      if (q_pop) begin
        clr_r <= (q_data.op == lahacc_pkg::OP_CLEAR);
        if (q_data.op == lahacc_pkg::OP_CLEAR) count_r <= '0;
      end
      if (ins_c) count_r <= count_r + CW'(1);
      if (state_r == E_OUT && out_free_c) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r  <= q_data;
      slot_r <= q_data.home;
      res_r  <= '{status: lahacc_pkg::ST_CLEARED, result_value: 32'd0,
                  entry_index: 10'd0};
    end
    if (state_r == E_OUT && out_free_c) out_r <= res_r;
    case (state_r)
      E_CHK_SLOT: begin
        ent_r <= slot_q.ent;
        if (slot_q.used) begin
          if (job_r.op == lahacc_pkg::OP_INSERT) slot_r <= slot_r + SW'(1);
        end else if (job_r.op == lahacc_pkg::OP_LOOKUP) begin
          res_r <= '{status: lahacc_pkg::ST_NOT_FOUND, result_value: 32'd0,
                     entry_index: 10'd0};
        end else if (full_c) begin
          res_r <= '{status: lahacc_pkg::ST_FULL, result_value: 32'd0,
                     entry_index: 10'd0};
        end else begin
          res_r <= '{status: lahacc_pkg::ST_INSERTED, result_value: job_r.value,
                     entry_index: 10'(e_c)};
        end
      end
      E_CHK_KEY: begin
        hi_r   <= hi_c;
        diff_r <= hi_c - lo_c;
        if (key_q != job_r.key) begin
          slot_r <= slot_r + SW'(1);
        end else begin
          res_r <= '{status: lahacc_pkg::ST_FOUND, result_value: val_q,
                     entry_index: 10'(ent_r)};
        end
      end
      E_LA_ROM: inrom_r <= (diff_r >> 10) < 32'(lahacc_pkg::CORRECTION_ROM_ENTRIES);
      E_LA_SUM: begin
        res_r <= '{status: lahacc_pkg::ST_COMBINED, result_value: sat_c,
                   entry_index: 10'(ent_r)};
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/log_add_hash_accumulator.sv
// ============================================================================
// log_add_hash_accumulator
// Open-addressed table keyed by (x, y) that accumulates Q16.16 log values.
// ============================================================================
// Usage
//   in_valid/in_stall/in_word : one command word (update, lookup, insert,
//     clear). Taken on a clock edge with in_valid high and in_stall low.
//   out_valid/out_stall/out_word : exactly one result word per command, in
//     command order. A stalled result holds in the output register.
//   cfg_wr_en/cfg_wr_data : max_entries; to be written only while idle, which the user must ensure.
// Operation
//   The front end hashes a key as five 64-bit products on one shared
//   32x32 multiplier and then hands it to a two-word queue; it takes a
//   new word only once it has pushed the last one into the queue.
//   For each probed slot the table engine does a slot read and a slot
//   check with key read, and for an update or lookup also a key compare,
//   which an insert skips; the log-add then does a ROM read and a
//   saturating add, and the result is loaded into the output register;
//   clear sweeps every slot.
// Reset
//   Synchronous, active low. Afterwards the engine clears all slots in a
//   sweep before taking the first queued word; the front end still
//   accepts up to three words meanwhile.
//   max_entries returns to 512.
// Back-pressure
//   out_stall holds the result; the engine waits in its output state, the
//   queue fills, and then the front end raises in_stall.
// ============================================================================
module log_add_hash_accumulator (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lahacc_pkg::in_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output lahacc_pkg::out_word_t out_word,
  input  logic                  cfg_wr_en,
  input  logic [9:0]            cfg_wr_data
);

  logic [9:0]       max_entries_r;
  logic             push, full, pop, pop_valid;
  lahacc_pkg::job_t push_data, pop_data;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_entries_r <= lahacc_pkg::MAX_ENTRIES_RST;
    end else if (cfg_wr_en) begin
      max_entries_r <= cfg_wr_data;
    end
  end

  // front end: accept and hash
  lahacc_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_push   (push),
    .q_data   (push_data),
    .q_full   (full)
  );

  // decoupling queue
  lahacc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_valid (pop_valid),
    .pop_data  (pop_data)
  );

  // back end: probe, combine, store, output register
  lahacc_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_entries (max_entries_r),
    .q_valid     (pop_valid),
    .q_data      (pop_data),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

FILE: hdl/lahacc_checker.sv
// ============================================================================
// lahacc_checker
// Port-level checks on the result channel.
// ============================================================================
module lahacc_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_stall,
  input lahacc_pkg::out_word_t out_word
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result changed while stalled");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_word.status <= lahacc_pkg::ST_CLEARED)
    else $error("undefined status code");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == lahacc_pkg::ST_NOT_FOUND ||
                  out_word.status == lahacc_pkg::ST_FULL ||
                  out_word.status == lahacc_pkg::ST_CLEARED)
    |-> out_word.result_value == 32'd0 && out_word.entry_index == 10'd0)
    else $error("non-zero payload on empty result");

  a_rst: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result present straight after reset");

endmodule

bind log_add_hash_accumulator lahacc_checker u_chk (.*);
